// File: rtl/mma_pkg.sv
// Shared types, constants and helpers for the Mahalanobis mode assignment core.
`timescale 1ns / 1ps
package mma_pkg;

   // Sizing
   localparam int MAX_MODES = 8;
   localparam int MAX_DIM   = 8;
   localparam int MODE_W    = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   // Datapath widths
   localparam int DATA_W  = 16;              // Q8.8 / Q4.12 storage
   localparam int DIFF_W  = DATA_W + 1;      // coordinate minus mean
   localparam int PROD_W  = DATA_W + DIFF_W; // factor times difference
   localparam int ACC_W   = PROD_W + DIM_W;  // row sum of products
   localparam int ABS_W   = 31;              // saturated row magnitude
   localparam int SQ_W    = 2 * ABS_W - 16;  // square truncated to Q30.16
   localparam int SUM_W   = SQ_W + DIM_W;
   localparam int HALF_W  = 47;              // saturated half distance
   localparam int SCORE_W = 48;
   localparam int TGT_W   = 32;
   localparam int BETA_W  = 16;
   localparam int BPROD_W = BETA_W + HALF_W;

   // Request commands
   typedef enum logic [1:0] {
      CMD_MEAN   = 2'd0,
      CMD_FACTOR = 2'd1,
      CMD_TARGET = 2'd2,
      CMD_POINT  = 2'd3
   } cmd_type;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_BETA  = 2'd0,
      CSR_MODES = 2'd1,
      CSR_DIM   = 2'd2
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // Position tags that travel with each product through the pipeline
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              first_col;
      logic              last_col;
      logic              first_row;
      logic              last_row;
      logic              last_mode;
   } step_flags_type;

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [31:0] v);
      if (v > 32'sd32767) begin
         return 16'sh7fff;
      end else if (v < -32'sd32768) begin
         return 16'sh8000;
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_7fff_ffff_ffff;
      lo = -64'sh0000_8000_0000_0000;
      if (v > hi) begin
         return hi[SCORE_W-1:0];
      end else if (v < lo) begin
         return lo[SCORE_W-1:0];
      end
      return v[SCORE_W-1:0];
   endfunction

endpackage

// File: rtl/mahalanobis_mode_assignment_core.sv
// A load request is written to its store as it is taken; a coordinate with last set raises
// rsp_valid once all M modes have been scored over its D coordinates.
// Throughput: one product per cycle through the single multiply-accumulate; every
// request stalls until the result is registered, and a last coordinate also waits
// while an earlier result is still held. Reset: synchronous; clears control state
// and sets beta 1.0, 8 modes, 8 dims. Store contents are undefined until written.
`timescale 1ns / 1ps
module mahalanobis_mode_assignment_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [2:0]         req_mode_index,
   input  logic [2:0]         req_row,
   input  logic [2:0]         req_column,
   input  logic signed [31:0] req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_mode_tempered,
   output logic [3:0]         rsp_mode_untempered,
   output logic signed [31:0] rsp_target_at_mode,
   output logic signed [47:0] rsp_tempered_score,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import mma_pkg::*;

   logic [BETA_W-1:0] beta_ff;
   logic [3:0]        mode_count_ff, dimension_ff;
   logic              busy_ff, busy_in;
   logic              accept, start, addr_ok_mode, addr_ok_row, addr_ok_col;
   logic signed [DATA_W-1:0] sat_value;

   logic              issue_valid;
   step_flags_type    issue_flags;
   logic [DIM_W-1:0]  issue_row, issue_col;
   logic signed [DATA_W-1:0] mean_rd, factor_rd, point_rd;
   logic              half_valid;
   step_flags_type    half_flags;
   logic [HALF_W-1:0] half;
   logic              res_valid;
   logic [3:0]        res_mode_t, res_mode_u;
   logic signed [TGT_W-1:0]   res_target;
   logic signed [SCORE_W-1:0] res_score;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_mode_t_ff, rsp_mode_u_ff;
   logic signed [TGT_W-1:0]   rsp_target_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff       <= 16'd16384;
         mode_count_ff <= 4'd8;
         dimension_ff  <= 4'd8;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BETA:  beta_ff       <= csr_data;
            CSR_MODES: mode_count_ff <= csr_data[3:0];
            CSR_DIM:   dimension_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Request decode; a last coordinate waits while a result is still held
   assign req_stall = busy_ff ||
                      (rsp_valid_ff && req_command == CMD_POINT && req_last);
   assign accept    = req_valid && !req_stall;
   assign start     = accept && req_command == CMD_POINT && req_last;
   assign sat_value = sat16(req_value);
   assign addr_ok_mode = int'(req_mode_index) < MAX_MODES;
   assign addr_ok_row  = int'(req_row) < MAX_DIM;
   assign addr_ok_col  = int'(req_column) < MAX_DIM;

   // Busy from a last coordinate until its result is registered
   assign busy_in = start ? 1'b1 : (res_valid ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   mma_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .mode_count  (mode_count_ff),
      .dimension   (dimension_ff),
      .issue_valid (issue_valid),
      .issue_flags (issue_flags),
      .issue_row   (issue_row),
      .issue_col   (issue_col)
   );

   mma_store u_store (
      .clock     (clock),
      .mean_we   (accept && req_command == CMD_MEAN && addr_ok_mode && addr_ok_row),
      .factor_we (accept && req_command == CMD_FACTOR && addr_ok_mode && addr_ok_row &&
                  addr_ok_col),
      .point_we  (accept && req_command == CMD_POINT && addr_ok_row),
      .wr_mode   (MODE_W'(req_mode_index)),
      .wr_row    (DIM_W'(req_row)),
      .wr_col    (DIM_W'(req_column)),
      .wr_data   (sat_value),
      .rd_mode   (issue_flags.mode),
      .rd_row    (issue_row),
      .rd_col    (issue_col),
      .mean_rd   (mean_rd),
      .factor_rd (factor_rd),
      .point_rd  (point_rd)
   );

   mma_distance u_distance (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_flags (issue_flags),
      .mean_rd     (mean_rd),
      .factor_rd   (factor_rd),
      .point_rd    (point_rd),
      .half_valid  (half_valid),
      .half_flags  (half_flags),
      .half        (half)
   );

   mma_select u_select (
      .clock               (clock),
      .reset               (reset),
      .target_we           (accept && req_command == CMD_TARGET && addr_ok_mode),
      .target_addr         (MODE_W'(req_mode_index)),
      .target_data         (req_value),
      .beta                (beta_ff),
      .half_valid          (half_valid),
      .half_flags          (half_flags),
      .half                (half),
      .res_valid           (res_valid),
      .res_mode_tempered   (res_mode_t),
      .res_mode_untempered (res_mode_u),
      .res_target          (res_target),
      .res_score           (res_score)
   );

   // Output register
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_mode_t_ff <= res_mode_t;
         rsp_mode_u_ff <= res_mode_u;
         rsp_target_ff <= res_target;
         rsp_score_ff  <= res_score;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode_tempered   = rsp_mode_t_ff;
   assign rsp_mode_untempered = rsp_mode_u_ff;
   assign rsp_target_at_mode  = rsp_target_ff;
   assign rsp_tempered_score  = rsp_score_ff;

   // No request is taken while a point is being scored
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> req_stall)
      else $error("request accepted while busy");

   // A new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !rsp_valid_ff)
      else $error("result overwritten");

   // Results only come while scoring, and scoring ends with them
   a_res_in_busy: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> busy_ff)
      else $error("result outside busy window");

   a_res_ends_busy: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> !busy_ff)
      else $error("busy held after result");

endmodule

// File: rtl/mma_sequencer.sv
// Walks mode, row and column indexes, one product per cycle.
`timescale 1ns / 1ps
module mma_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [3:0]                 mode_count,
   input  logic [3:0]                 dimension,
   output logic                       issue_valid,
   output mma_pkg::step_flags_type    issue_flags,
   output logic [mma_pkg::DIM_W-1:0]  issue_row,
   output logic [mma_pkg::DIM_W-1:0]  issue_col
);
   import mma_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [MODE_W-1:0] mode_last;
   logic [DIM_W-1:0]  dim_last;

   // Clamp the configured counts into the supported range
   always_comb begin
      if (mode_count == 4'd0) begin
         mode_last = '0;
      end else if (int'(mode_count) > MAX_MODES) begin
         mode_last = MODE_W'(MAX_MODES - 1);
      end else begin
         mode_last = MODE_W'(mode_count - 4'd1);
      end
      if (dimension == 4'd0) begin
         dim_last = '0;
      end else if (int'(dimension) > MAX_DIM) begin
         dim_last = DIM_W'(MAX_DIM - 1);
      end else begin
         dim_last = DIM_W'(dimension - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         mode_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   // Lower triangle walk: col 0..row, row 0..dim-1, mode 0..count-1
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               mode_in  = '0;
               row_in   = '0;
               col_in   = '0;
            end
         end
         SEQ_RUN: begin
            if (col_ff == row_ff) begin
               col_in = '0;
               if (row_ff == dim_last) begin
                  row_in = '0;
                  if (mode_ff == mode_last) begin
                     state_in = SEQ_IDLE;
                  end else begin
                     mode_in = mode_ff + 1'b1;
                  end
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign issue_valid           = (state_ff == SEQ_RUN);
   assign issue_row             = row_ff;
   assign issue_col             = col_ff;
   assign issue_flags.mode      = mode_ff;
   assign issue_flags.first_col = (col_ff == '0);
   assign issue_flags.last_col  = (col_ff == row_ff);
   assign issue_flags.first_row = (row_ff == '0);
   assign issue_flags.last_row  = (row_ff == dim_last);
   assign issue_flags.last_mode = (mode_ff == mode_last);

endmodule

// File: rtl/mma_store.sv
// Mean and factor memories plus the point buffer, all with registered reads.
`timescale 1ns / 1ps
module mma_store (
   input  logic                              clock,
   input  logic                              mean_we,
   input  logic                              factor_we,
   input  logic                              point_we,
   input  logic [mma_pkg::MODE_W-1:0]        wr_mode,
   input  logic [mma_pkg::DIM_W-1:0]         wr_row,
   input  logic [mma_pkg::DIM_W-1:0]         wr_col,
   input  logic signed [mma_pkg::DATA_W-1:0] wr_data,
   input  logic [mma_pkg::MODE_W-1:0]        rd_mode,
   input  logic [mma_pkg::DIM_W-1:0]         rd_row,
   input  logic [mma_pkg::DIM_W-1:0]         rd_col,
   output logic signed [mma_pkg::DATA_W-1:0] mean_rd,
   output logic signed [mma_pkg::DATA_W-1:0] factor_rd,
   output logic signed [mma_pkg::DATA_W-1:0] point_rd
);
   import mma_pkg::*;

   localparam int MEAN_AW   = MODE_W + DIM_W;
   localparam int FACTOR_AW = MODE_W + 2 * DIM_W;

   logic signed [DATA_W-1:0] mean_mem   [2**MEAN_AW];
   logic signed [DATA_W-1:0] factor_mem [2**FACTOR_AW];
   logic signed [DATA_W-1:0] point_ff   [MAX_DIM];

   // Mean memory
   always_ff @(posedge clock) begin
      if (mean_we) begin
         mean_mem[{wr_mode, wr_row}] <= wr_data;
      end
      mean_rd <= mean_mem[{rd_mode, rd_col}];
   end

   // Factor memory, row-major per mode
   always_ff @(posedge clock) begin
      if (factor_we) begin
         factor_mem[{wr_mode, wr_row, wr_col}] <= wr_data;
      end
      factor_rd <= factor_mem[{rd_mode, rd_row, rd_col}];
   end

   // Point buffer
   always_ff @(posedge clock) begin
      if (point_we) begin
         point_ff[wr_row] <= wr_data;
      end
      point_rd <= point_ff[rd_col];
   end

endmodule

// File: rtl/mma_distance.sv
// Shared multiply-accumulate pipeline forming each mode's half squared distance.
`timescale 1ns / 1ps
module mma_distance (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              issue_valid,
   input  mma_pkg::step_flags_type           issue_flags,
   input  logic signed [mma_pkg::DATA_W-1:0] mean_rd,
   input  logic signed [mma_pkg::DATA_W-1:0] factor_rd,
   input  logic signed [mma_pkg::DATA_W-1:0] point_rd,
   output logic                              half_valid,
   output mma_pkg::step_flags_type           half_flags,
   output logic [mma_pkg::HALF_W-1:0]        half
);
   import mma_pkg::*;

   localparam logic signed [ACC_W:0] ROW_HI = (ACC_W + 1)'(64'sd2147483647);
   localparam logic signed [ACC_W:0] ROW_LO = -ROW_HI;
   localparam logic [SUM_W-1:0]      HALF_MAX = SUM_W'({HALF_W{1'b1}});

   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   step_flags_type            f1_ff, f2_ff, f3_ff, f4_ff, f5_ff;
   logic signed [PROD_W-1:0]  factor_ext, diff_ext, prod_in, prod_ff;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W:0]     rounded, row_val;
   logic [ABS_W-1:0]          abs_ff, abs_in;
   logic [2*ABS_W-1:0]        square;
   logic [SQ_W-1:0]           sq_ff;
   logic [SUM_W-1:0]          sum_ff, sum_in, halved;

   // Valid and tag pipeline (memory read, product, accumulate, abs, square)
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= issue_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && f2_ff.last_col;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_ff <= issue_flags;
      f2_ff <= f1_ff;
      f3_ff <= f2_ff;
      f4_ff <= f3_ff;
      f5_ff <= f4_ff;
   end

   // Product of factor and centered coordinate
   assign diff       = DIFF_W'(point_rd) - DIFF_W'(mean_rd);
   assign factor_ext = PROD_W'(factor_rd);
   assign diff_ext   = PROD_W'(diff);
   assign prod_in    = factor_ext * diff_ext;

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prod_ff <= prod_in;
      end
   end

   // Row accumulation
   assign acc_in = f2_ff.first_col ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Round half up to Q.16, saturate, take magnitude
   always_comb begin
      rounded = ((ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(8)) >>> 4;
      if (rounded > ROW_HI) begin
         row_val = ROW_HI;
      end else if (rounded < ROW_LO) begin
         row_val = ROW_LO;
      end else begin
         row_val = rounded;
      end
      abs_in = row_val[ACC_W] ? ABS_W'(-row_val) : ABS_W'(row_val);
   end

   always_ff @(posedge clock) begin
      if (v3_ff) begin
         abs_ff <= abs_in;
      end
   end

   // Square, truncated to Q30.16
   assign square = (2 * ABS_W)'(abs_ff) * (2 * ABS_W)'(abs_ff);

   always_ff @(posedge clock) begin
      if (v4_ff) begin
         sq_ff <= square[2*ABS_W-1:16];
      end
   end

   // Sum of squares over the rows of a mode
   assign sum_in = f5_ff.first_row ? SUM_W'(sq_ff) : sum_ff + SUM_W'(sq_ff);

   always_ff @(posedge clock) begin
      if (v5_ff) begin
         sum_ff <= sum_in;
      end
   end

   logic             v6_ff;
   step_flags_type   f6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff && f5_ff.last_row;
      end
   end

   always_ff @(posedge clock) begin
      f6_ff <= f5_ff;
   end

   // Halve and saturate
   assign halved     = sum_ff >> 1;
   assign half       = (halved > HALF_MAX) ? {HALF_W{1'b1}} : halved[HALF_W-1:0];
   assign half_valid = v6_ff;
   assign half_flags = f6_ff;

endmodule

// File: rtl/mma_select.sv
// Target memory, tempered scoring and running argmax over modes.
`timescale 1ns / 1ps
module mma_select (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               target_we,
   input  logic [mma_pkg::MODE_W-1:0]         target_addr,
   input  logic signed [mma_pkg::TGT_W-1:0]   target_data,
   input  logic [mma_pkg::BETA_W-1:0]         beta,
   input  logic                               half_valid,
   input  mma_pkg::step_flags_type            half_flags,
   input  logic [mma_pkg::HALF_W-1:0]         half,
   output logic                               res_valid,
   output logic [3:0]                         res_mode_tempered,
   output logic [3:0]                         res_mode_untempered,
   output logic signed [mma_pkg::TGT_W-1:0]   res_target,
   output logic signed [mma_pkg::SCORE_W-1:0] res_score
);
   import mma_pkg::*;

   logic signed [TGT_W-1:0]   target_mem [MAX_MODES];
   logic signed [TGT_W-1:0]   tgt_a_ff, tgt_b_ff;
   logic [HALF_W-1:0]         half_a_ff;
   logic                      va_ff, vb_ff;
   step_flags_type            fa_ff, fb_ff;
   logic [BPROD_W-1:0]        bprod_ff;
   logic signed [SCORE_W-1:0] su_in, su_ff, st;
   logic [63:0]               bh;
   logic                      take_t, take_u;

   logic [MODE_W-1:0]         best_t_mode_ff, best_u_mode_ff;
   logic signed [SCORE_W-1:0] best_t_score_ff, best_u_score_ff;
   logic signed [TGT_W-1:0]   best_t_tgt_ff;

   // Target memory
   always_ff @(posedge clock) begin
      if (target_we) begin
         target_mem[target_addr] <= target_data;
      end
      tgt_a_ff <= target_mem[half_flags.mode];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= half_valid;
         vb_ff <= va_ff;
      end
   end

   // Stage A: half distance lines up with the target read
   always_ff @(posedge clock) begin
      half_a_ff <= half;
      fa_ff     <= half_flags;
   end

   // Stage B: untempered score and beta product
   assign su_in = sat_score(64'(tgt_a_ff) - $signed(64'(half_a_ff)));

   always_ff @(posedge clock) begin
      if (va_ff) begin
         bprod_ff <= BPROD_W'(beta) * BPROD_W'(half_a_ff);
         su_ff    <= su_in;
         tgt_b_ff <= tgt_a_ff;
         fb_ff    <= fa_ff;
      end
   end

   // Stage C: tempered score and compare, ties keep the lower mode
   always_comb begin
      bh     = (64'(bprod_ff) + 64'd8192) >> 14;
      st     = sat_score(64'(tgt_b_ff) - $signed(bh));
      take_t = (fb_ff.mode == '0) || (st > best_t_score_ff);
      take_u = (fb_ff.mode == '0) || (su_ff > best_u_score_ff);
   end

   always_ff @(posedge clock) begin
      if (vb_ff) begin
         if (take_t) begin
            best_t_mode_ff  <= fb_ff.mode;
            best_t_score_ff <= st;
            best_t_tgt_ff   <= tgt_b_ff;
         end
         if (take_u) begin
            best_u_mode_ff  <= fb_ff.mode;
            best_u_score_ff <= su_ff;
         end
      end
   end

   // Widen before adding one so mode 8 does not wrap
   assign res_valid           = vb_ff && fb_ff.last_mode;
   assign res_mode_tempered   = take_t ? (4'(fb_ff.mode) + 4'd1) : (4'(best_t_mode_ff) + 4'd1);
   assign res_mode_untempered = take_u ? (4'(fb_ff.mode) + 4'd1) : (4'(best_u_mode_ff) + 4'd1);
   assign res_target          = take_t ? tgt_b_ff : best_t_tgt_ff;
   assign res_score           = take_t ? st : best_t_score_ff;

endmodule
